// File: src/acd_pkg.sv
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types, constants and lookup helpers for the affine cipher decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package acd_pkg;

    // alphabet sizes and field widths
    localparam int MIXED_SIZE  = 92;
    localparam int SMALL_SIZE  = 27;
    localparam int CHAR_W      = 8;
    localparam int KEY_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int MIX_IDX_W   = 7;
    localparam int SMALL_IDX_W = 5;
    localparam int PROD_W      = 14;

    // character codes used by the classifier
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h21;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIG_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9   = 8'h39;

    // reciprocal constants for the final reduction (slight underestimates)
    localparam logic [9:0]  RECIP_MIXED = 10'd712;
    localparam logic [11:0] RECIP_SMALL = 12'd2427;

    // mixed alphabet, first symbol in the top byte
    localparam logic [8*MIXED_SIZE-1:0] MIXED_ALPHA =
        " ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!@#$%^&*()-_=+[]{}|;:',.<>/?~";

    typedef enum logic [1:0] {
        CMD_SCAN   = 2'd0,
        CMD_DECODE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_MULT   = 2'd0,
        REG_KEY_OFFSET = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ALPH_MIXED = 2'd0,
        ALPH_UPPER = 2'd1,
        ALPH_LOWER = 2'd2,
        ALPH_NONE  = 2'd3
    } alph_t;

    typedef struct packed {
        logic upper;
        logic lower;
        logic digit;
        logic punct;
    } flags_t;

    typedef struct packed {
        logic                 found;
        logic [MIX_IDX_W-1:0] idx;
    } sym_t;

    typedef logic [SMALL_IDX_W-1:0] small_tab_t [256];
    typedef logic [MIX_IDX_W-1:0]   mixed_tab_t [256];

    // modular inverse by search, elaboration only
    // running product r*x kept reduced by compare and subtract
    function automatic int inverse_mod(input int a, input int m);
        int r;
        int acc;
        int res;
        r = a;
        while (r >= m)
        begin
            r = r - m;
        end
        acc = 0;
        res = 0;
        for (int x = 1; x < m; x++)
        begin
            acc = acc + r;
            if (acc >= m)
            begin
                acc = acc - m;
            end
            if (acc == 1 && res == 0)
            begin
                res = x;
            end
        end
        return res;
    endfunction

    function automatic small_tab_t build_inv_small();
        small_tab_t t;
        for (int a = 0; a < 256; a++) begin
            t[a] = SMALL_IDX_W'(inverse_mod(a, SMALL_SIZE));
        end
        return t;
    endfunction

    function automatic mixed_tab_t build_inv_mixed();
        mixed_tab_t t;
        for (int a = 0; a < 256; a++) begin
            t[a] = MIX_IDX_W'(inverse_mod(a, MIXED_SIZE));
        end
        return t;
    endfunction

    function automatic small_tab_t build_mod_small();
        small_tab_t t;
        for (int a = 0; a < 256; a++) begin
            t[a] = SMALL_IDX_W'(a % SMALL_SIZE);
        end
        return t;
    endfunction

    localparam small_tab_t INV_SMALL_TAB = build_inv_small();
    localparam mixed_tab_t INV_MIXED_TAB = build_inv_mixed();
    localparam small_tab_t MOD_SMALL_TAB = build_mod_small();

    // position of a character in the mixed alphabet, symbols are unique
    function automatic sym_t mixed_index(input logic [CHAR_W-1:0] c);
        sym_t s;
        s = '0;
        for (int j = 0; j < MIXED_SIZE; j++) begin
            if (c == MIXED_ALPHA[8*(MIXED_SIZE-1-j) +: 8]) begin
                s.found = 1'b1;
                s.idx   = s.idx | MIX_IDX_W'(j);
            end
        end
        return s;
    endfunction

    // mixed alphabet symbol at a position below the alphabet size
    function automatic logic [CHAR_W-1:0] mixed_char(input logic [MIX_IDX_W-1:0] x);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        for (int j = 0; j < MIXED_SIZE; j++) begin
            if (x == MIX_IDX_W'(j)) begin
                ch = ch | MIXED_ALPHA[8*(MIXED_SIZE-1-j) +: 8];
            end
        end
        return ch;
    endfunction

    // position in space plus capitals or space plus small letters
    function automatic sym_t small_index(input logic [CHAR_W-1:0] c, input logic upper);
        sym_t s;
        s = '0;
        if (c == CH_SPACE) begin
            s.found = 1'b1;
        end else if (upper && c >= CH_UP_A && c <= CH_UP_Z) begin
            s.found = 1'b1;
            s.idx   = MIX_IDX_W'(c - CH_UP_A + 8'd1);
        end else if (!upper && c >= CH_LO_A && c <= CH_LO_Z) begin
            s.found = 1'b1;
            s.idx   = MIX_IDX_W'(c - CH_LO_A + 8'd1);
        end
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] small_char(input logic [SMALL_IDX_W-1:0] x,
                                                     input logic upper);
        logic [CHAR_W-1:0] ch;
        if (x == '0) begin
            ch = CH_SPACE;
        end else if (upper) begin
            ch = CH_UP_A + CHAR_W'(x) - 8'd1;
        end else begin
            ch = CH_LO_A + CHAR_W'(x) - 8'd1;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: src/acd_in_if.sv
// ----------------------------------------------------------------------------
// acd_in_if
// Input channel: command and character beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface acd_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [acd_pkg::CHAR_W-1:0]    char_in;

    modport source (output valid, output cmd, output char_in, input ready);
    modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

`default_nettype wire

// File: src/acd_out_if.sv
// ----------------------------------------------------------------------------
// acd_out_if
// Result channel: decoded character beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface acd_out_if;
    logic                          valid;
    logic                          ready;
    logic [acd_pkg::CHAR_W-1:0]    char_out;
    logic                          no_letters;

    modport source (output valid, output char_out, output no_letters, input ready);
    modport sink   (input valid, input char_out, input no_letters, output ready);
endinterface

`default_nettype wire

// File: src/acd_cfg_if.sv
// ----------------------------------------------------------------------------
// acd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface acd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [acd_pkg::CFG_IDX_W-1:0]  index;
    logic [acd_pkg::KEY_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/affine_cipher_decoder.sv
// ----------------------------------------------------------------------------
// affine_cipher_decoder
// Character-stream affine cipher decoder over three alphabets.
//
// Usage:
//   din  carries one beat per character: cmd scan (classify and set sticky
//        flags), decode, or clear flags. dout carries one beat per decode
//        whose character is in the selected alphabet, or a beat with
//        no_letters set when no letter has been scanned yet.
//   cfg  writes key_multiplier (index 0) and key_offset (index 1); the
//        modular inverses and reduced offsets are computed on the write.
//        cfg is always ready; write it only while the block is idle.
// Timing:
//   three stages (input register, multiply register, result register);
//   an accepted beat passes through them in that order to reach dout.
//   One beat per cycle sustained while dout.ready stays high.
// Reset:
//   flags cleared, key 1 / offset 0, pipeline empty.
// Stall:
//   dout holds its beat while ready is low; the pipeline keeps filling
//   bubbles and then drops din.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_cipher_decoder (
    input  wire logic clk,
    input  wire logic rst_n,
    acd_in_if.sink    din,
    acd_out_if.source dout,
    acd_cfg_if.sink   cfg
);
    import acd_pkg::*;

    // key derived state
    logic [SMALL_IDX_W-1:0] inv_small_reg, off_small_reg;
    logic [MIX_IDX_W-1:0]   inv_mixed_reg, off_mixed_reg;
    logic [MIX_IDX_W-1:0]   off_mixed_next;

    // sticky flags
    flags_t flags_reg, flags_next;

    // input stage
    logic              s0_vld_reg;
    logic [1:0]        s0_cmd_reg;
    logic [CHAR_W-1:0] s0_char_reg;

    // multiply stage
    logic              s1_vld_reg, s1_emit_reg;
    alph_t             s1_alph_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s1_emit_next;
    alph_t             s1_alph_next;
    logic [PROD_W-1:0] s1_prod_next;

    // result stage
    logic              out_vld_reg, nol_reg;
    logic [CHAR_W-1:0] char_reg, char_next;

    logic rdy_out, rdy1, rdy0, adv0;

    // backpressure chain
    assign rdy_out   = !out_vld_reg || dout.ready;
    assign rdy1      = !s1_vld_reg || rdy_out;
    assign rdy0      = !s0_vld_reg || rdy1;
    assign adv0      = s0_vld_reg && rdy1;
    assign din.ready = rdy0;
    assign cfg.ready = 1'b1;

    // offset of the mixed alphabet: b below 3 * 92
    always_comb
    begin
        if (cfg.data >= KEY_W'(2 * MIXED_SIZE))
        begin
            off_mixed_next = MIX_IDX_W'(cfg.data - KEY_W'(2 * MIXED_SIZE));
        end
        else if (cfg.data >= KEY_W'(MIXED_SIZE))
        begin
            off_mixed_next = MIX_IDX_W'(cfg.data - KEY_W'(MIXED_SIZE));
        end
        else
        begin
            off_mixed_next = MIX_IDX_W'(cfg.data);
        end
    end

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_small_reg <= SMALL_IDX_W'(1);
            inv_mixed_reg <= MIX_IDX_W'(1);
            off_small_reg <= '0;
            off_mixed_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_KEY_MULT)
            begin
                inv_small_reg <= INV_SMALL_TAB[cfg.data];
                inv_mixed_reg <= INV_MIXED_TAB[cfg.data];
            end
            else if (cfg.index == REG_KEY_OFFSET)
            begin
                off_small_reg <= MOD_SMALL_TAB[cfg.data];
                off_mixed_reg <= off_mixed_next;
            end
        end
    end

    // flag update as an item leaves the input stage
    always_comb
    begin
        flags_next = flags_reg;
        if (adv0)
        begin
            if (s0_cmd_reg == CMD_CLEAR)
            begin
                flags_next = '0;
            end
            else if (s0_cmd_reg == CMD_SCAN)
            begin
                priority if (s0_char_reg >= CH_UP_A && s0_char_reg <= CH_UP_Z)
                    flags_next.upper = 1'b1;
                else if (s0_char_reg >= CH_LO_A && s0_char_reg <= CH_LO_Z)
                    flags_next.lower = 1'b1;
                else if (s0_char_reg >= CH_DIG_0 && s0_char_reg <= CH_DIG_9)
                    flags_next.digit = 1'b1;
                else if (s0_char_reg >= CH_PRINT_LO && s0_char_reg <= CH_PRINT_HI)
                    flags_next.punct = 1'b1;
                else
                    flags_next.punct = flags_reg.punct;
            end
        end
    end

    // decode front: alphabet choice, index, offset removal, multiply
    always_comb
    begin
        sym_t                 sym;
        logic [MIX_IDX_W-1:0] off, z, dval;
        logic [7:0]           sum, nsize;
        logic [PROD_W-1:0]    prod;

        if ((flags_reg.upper || flags_reg.lower) && (flags_reg.digit || flags_reg.punct))
            s1_alph_next = ALPH_MIXED;
        else if (flags_reg.upper)
            s1_alph_next = ALPH_UPPER;
        else if (flags_reg.lower)
            s1_alph_next = ALPH_LOWER;
        else
            s1_alph_next = ALPH_NONE;

        if (s1_alph_next == ALPH_MIXED)
        begin
            sym   = mixed_index(s0_char_reg);
            off   = off_mixed_reg;
            z     = inv_mixed_reg;
            nsize = 8'(MIXED_SIZE);
        end
        else
        begin
            sym   = small_index(s0_char_reg, s1_alph_next == ALPH_UPPER);
            off   = MIX_IDX_W'(off_small_reg);
            z     = MIX_IDX_W'(inv_small_reg);
            nsize = 8'(SMALL_SIZE);
        end

        sum  = 8'(sym.idx) + nsize - 8'(off);
        dval = (sum >= nsize) ? MIX_IDX_W'(sum - nsize) : MIX_IDX_W'(sum);
        prod = dval * z;
        s1_prod_next = prod;

        s1_emit_next = (s0_cmd_reg == CMD_DECODE)
                       && (s1_alph_next == ALPH_NONE || sym.found);
    end

    // decode back: reduction by the alphabet size and symbol lookup
    always_comb
    begin
        logic [22:0] qm_full;
        logic [21:0] qs_full;
        logic [13:0] rm;
        logic [10:0] rs;
        logic [MIX_IDX_W-1:0]   xm;
        logic [SMALL_IDX_W-1:0] xs;

        qm_full = 23'(s1_prod_reg) * 23'(RECIP_MIXED);
        rm      = 14'(s1_prod_reg) - 14'(qm_full[22:16]) * 14'(MIXED_SIZE);
        xm      = (rm >= 14'(MIXED_SIZE)) ? MIX_IDX_W'(rm - 14'(MIXED_SIZE))
                                          : MIX_IDX_W'(rm);

        qs_full = 22'(s1_prod_reg[9:0]) * 22'(RECIP_SMALL);
        rs      = 11'(s1_prod_reg[9:0]) - 11'(qs_full[21:16]) * 11'(SMALL_SIZE);
        xs      = (rs >= 11'(SMALL_SIZE)) ? SMALL_IDX_W'(rs - 11'(SMALL_SIZE))
                                          : SMALL_IDX_W'(rs);

        unique case (s1_alph_reg)
            ALPH_MIXED: char_next = mixed_char(xm);
            ALPH_UPPER: char_next = small_char(xs, 1'b1);
            ALPH_LOWER: char_next = small_char(xs, 1'b0);
            default:    char_next = '0;
        endcase
    end

    // pipeline control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (rdy0)
                s0_vld_reg <= din.valid;
            if (rdy1)
                s1_vld_reg <= s0_vld_reg;
            if (rdy_out)
                out_vld_reg <= s1_vld_reg && s1_emit_reg;
        end
    end

    // pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            s0_cmd_reg  <= din.cmd;
            s0_char_reg <= din.char_in;
        end
        if (rdy1)
        begin
            s1_emit_reg <= s1_emit_next;
            s1_alph_reg <= s1_alph_next;
            s1_prod_reg <= s1_prod_next;
        end
        if (rdy_out)
        begin
            char_reg <= char_next;
            nol_reg  <= (s1_alph_reg == ALPH_NONE);
        end
    end

    assign dout.valid      = out_vld_reg;
    assign dout.char_out   = char_reg;
    assign dout.no_letters = nol_reg;

    // invalid-message beats carry a zero character
    a_nol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.no_letters) |-> (dout.char_out == '0))
        else $error("no_letters beat with nonzero character");

    // product stays below the square of the alphabet size
    a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && s1_emit_reg && s1_alph_reg == ALPH_MIXED)
            |-> (s1_prod_reg < PROD_W'(MIXED_SIZE * MIXED_SIZE)))
        else $error("mixed product out of range");

    // clear leaves every flag low
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv0 && s0_cmd_reg == CMD_CLEAR) |=> (flags_reg == '0))
        else $error("flags not cleared");

    // derived key state stays inside the alphabets
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_small_reg < SMALL_IDX_W'(SMALL_SIZE)) && (off_small_reg < SMALL_IDX_W'(SMALL_SIZE))
        && (inv_mixed_reg < MIX_IDX_W'(MIXED_SIZE)) && (off_mixed_reg < MIX_IDX_W'(MIXED_SIZE)))
        else $error("key state out of range");

endmodule

`default_nettype wire
